FILE: rtl/core/slmp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// slmp_pkg
// Shared types, constants and the threshold table for the log-magnitude
// pixel core.
// ============================================================================
package slmp_pkg;

    localparam int LEVELS     = 256;
    localparam int LEVEL_BITS = 8;
    localparam int THR_BITS   = 40;
    localparam int M2_BITS    = 64;
    localparam int FIX_BITS   = 192;
    localparam int FRAC_BITS  = 96;
    localparam int SERIES_N   = 40;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef logic [THR_BITS-1:0]                t_thr;
    typedef logic [LEVELS-1:0][THR_BITS-1:0]    t_thr_table;
    typedef logic [LEVEL_BITS-1:0]              t_level;
    typedef logic [M2_BITS-1:0]                 t_m2;

    // Shift-subtract division of a fixed-point word by a small integer.
    function automatic logic [FIX_BITS-1:0] f_div_small(
        input logic [FIX_BITS-1:0] a,
        input logic [9:0]          d
    );
        logic [FIX_BITS-1:0] q;
        logic [10:0]         rem;
        q   = '0;
        rem = '0;
        for (int i = FIX_BITS - 1; i >= 0; i--) begin
            rem = {rem[9:0], a[i]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Table of ceil(exp(k/10)), built from exp(0.1) summed as a series and
    // raised to successive powers in fixed point with 96 fraction bits.
    function automatic t_thr_table f_build_thr();
        t_thr_table            tbl;
        logic [FIX_BITS-1:0]   term;
        logic [FIX_BITS-1:0]   step;
        logic [FIX_BITS-1:0]   val;
        logic [2*FIX_BITS-1:0] prod;
        logic [63:0]           ip;
        term = '0;
        term[FRAC_BITS] = 1'b1;
        step = term;
        for (int n = 1; n <= SERIES_N; n++) begin
            term = f_div_small(term, 10'(10 * n));
            step = step + term;
        end
        val = '0;
        val[FRAC_BITS] = 1'b1;
        for (int k = 0; k < LEVELS; k++) begin
            ip = val[FRAC_BITS+63:FRAC_BITS];
            if (val[FRAC_BITS-1:0] != '0) begin
                ip = ip + 64'd1;
            end
            tbl[k] = ip[THR_BITS-1:0];
            prod = {{FIX_BITS{1'b0}}, val} * {{FIX_BITS{1'b0}}, step};
            val  = prod[FRAC_BITS+FIX_BITS-1:FRAC_BITS];
        end
        return tbl;
    endfunction

    localparam t_thr_table THR_TABLE = f_build_thr();

endpackage

FILE: rtl/core/slmp_if.sv
`timescale 1ns / 1ps
// ============================================================================
// slmp_if
// Valid/ready channels for coefficient beats and pixel beats.
// ============================================================================
interface slmp_coef_if #(
    parameter int COEFF_BITS = 32
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COEFF_BITS-1:0] re_part;
    logic signed [COEFF_BITS-1:0] imag_part;
    logic                         last_coefficient;

    modport source(output valid, output re_part, output imag_part,
                   output last_coefficient, input ready);
    modport sink(input valid, input re_part, input imag_part,
                 input last_coefficient, output ready);
endinterface

interface slmp_pix_if ();
    logic       valid;
    logic       ready;
    logic [7:0] grey_level;
    logic [7:0] alpha_level;
    logic       last_pixel;

    modport source(output valid, output grey_level, output alpha_level,
                   output last_pixel, input ready);
    modport sink(input valid, input grey_level, input alpha_level,
                 input last_pixel, output ready);
endinterface

FILE: rtl/core/spectrum_log_magnitude_pixel_core.sv
`timescale 1ns / 1ps
// A beat passes the input, squaring and sum registers, then the search stages.
// Throughput: one beat per cycle while the output is not stalled; every stage
// has its own valid bit, so bubbles close up and a stalled output stops only
// the stages behind. Threshold search: eight stages, one table compare each.
// Reset: synchronous, active low; clears all valid bits and holds the input
// ready low, payload is not reset.
// ============================================================================
// spectrum_log_magnitude_pixel_core
// Grey preview pixel floor(20*ln|c|) from one complex spectrum coefficient.
// ============================================================================
module spectrum_log_magnitude_pixel_core #(
    parameter int COEFF_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    slmp_coef_if.sink       i_coef,
    slmp_pix_if.source      o_pix
);
    import slmp_pkg::*;

    localparam int NSTG = 11;
    localparam int MW   = 2 * COEFF_BITS;

    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   n_rdy;

    logic signed [COEFF_BITS-1:0] r_re;
    logic signed [COEFF_BITS-1:0] r_im;
    logic [2:0]                   r_last_sh;
    logic [MW-1:0]                w_sq_re;
    logic [MW-1:0]                w_sq_im;
    t_m2                          r_m2;

    t_m2    w_m2  [9];
    t_level w_lvl [9];
    logic   w_last[9];

    always_comb begin
        n_rdy[NSTG] = o_pix.ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            n_rdy[i] = !r_v[i] || n_rdy[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (n_rdy[0]) begin
                r_v[0] <= i_coef.valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (n_rdy[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy[0]) begin
            r_re         <= i_coef.re_part;
            r_im         <= i_coef.imag_part;
            r_last_sh[0] <= i_coef.last_coefficient;
        end
        if (n_rdy[1]) begin
            r_last_sh[1] <= r_last_sh[0];
        end
        if (n_rdy[2]) begin
            r_m2         <= M2_BITS'(w_sq_re + w_sq_im);
            r_last_sh[2] <= r_last_sh[1];
        end
    end

    slmp_square #(
        .COEFF_BITS(COEFF_BITS)
    ) u_square (
        .i_clk   (i_clk),
        .i_en    (n_rdy[1]),
        .i_re    (r_re),
        .i_im    (r_im),
        .o_sq_re (w_sq_re),
        .o_sq_im (w_sq_im)
    );

    assign w_m2[0]   = r_m2;
    assign w_lvl[0]  = '0;
    assign w_last[0] = r_last_sh[2];

    for (genvar g = 0; g < 8; g++) begin : g_search
        slmp_search_stage #(
            .BIT_POS(7 - g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_en    (n_rdy[3+g]),
            .i_m2    (w_m2[g]),
            .i_level (w_lvl[g]),
            .i_last  (w_last[g]),
            .o_m2    (w_m2[g+1]),
            .o_level (w_lvl[g+1]),
            .o_last  (w_last[g+1])
        );
    end

    assign i_coef.ready      = n_rdy[0] && i_rst_n;
    assign o_pix.valid       = r_v[NSTG-1];
    assign o_pix.grey_level  = w_lvl[8];
    assign o_pix.alpha_level = ALPHA_OPAQUE;
    assign o_pix.last_pixel  = w_last[8];
endmodule

FILE: rtl/core/slmp_square.sv
`timescale 1ns / 1ps
// ============================================================================
// slmp_square
// Magnitude of each part and its registered square.
// ============================================================================
module slmp_square #(
    parameter int COEFF_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COEFF_BITS-1:0]  i_re,
    input  logic signed [COEFF_BITS-1:0]  i_im,
    output logic [2*COEFF_BITS-1:0]       o_sq_re,
    output logic [2*COEFF_BITS-1:0]       o_sq_im
);
    logic [COEFF_BITS-1:0]   n_abs_re;
    logic [COEFF_BITS-1:0]   n_abs_im;
    logic [2*COEFF_BITS-1:0] r_sq_re;
    logic [2*COEFF_BITS-1:0] r_sq_im;

    // The most negative value maps to 2^(COEFF_BITS-1), which still fits unsigned.
    assign n_abs_re = i_re[COEFF_BITS-1] ? (~i_re + 1'b1) : i_re;
    assign n_abs_im = i_im[COEFF_BITS-1] ? (~i_im + 1'b1) : i_im;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_re <= {{COEFF_BITS{1'b0}}, n_abs_re} * {{COEFF_BITS{1'b0}}, n_abs_re};
            r_sq_im <= {{COEFF_BITS{1'b0}}, n_abs_im} * {{COEFF_BITS{1'b0}}, n_abs_im};
        end
    end

    assign o_sq_re = r_sq_re;
    assign o_sq_im = r_sq_im;
endmodule

FILE: rtl/core/slmp_search_stage.sv
`timescale 1ns / 1ps
// ============================================================================
// slmp_search_stage
// One step of the binary search for the largest level whose threshold the
// squared magnitude reaches.
// ============================================================================
module slmp_search_stage #(
    parameter int BIT_POS = 7
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  slmp_pkg::t_m2         i_m2,
    input  slmp_pkg::t_level      i_level,
    input  logic                  i_last,
    output slmp_pkg::t_m2         o_m2,
    output slmp_pkg::t_level      o_level,
    output logic                  o_last
);
    import slmp_pkg::*;

    t_level n_cand;
    t_level n_level;
    t_m2    r_m2;
    t_level r_level;
    logic   r_last;

    always_comb begin
        n_cand          = i_level;
        n_cand[BIT_POS] = 1'b1;
        n_level = (i_m2 >= M2_BITS'(THR_TABLE[n_cand])) ? n_cand : i_level;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m2    <= i_m2;
            r_level <= n_level;
            r_last  <= i_last;
        end
    end

    assign o_m2    = r_m2;
    assign o_level = r_level;
    assign o_last  = r_last;
endmodule

FILE: rtl/core/slmp_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// slmp_checker
// Port-level checks for the log-magnitude pixel core, bound to the top level.
// ============================================================================
module slmp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_grey,
    input logic [7:0] i_alpha,
    input logic       i_last
);
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("pixel valid after reset");

    a_alpha_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_alpha == 8'd255)
        else $error("alpha is not opaque");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_grey) && $stable(i_last))
        else $error("stalled pixel beat changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");
endmodule

bind spectrum_log_magnitude_pixel_core slmp_checker u_slmp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_coef.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_grey      (o_pix.grey_level),
    .i_alpha     (o_pix.alpha_level),
    .i_last      (o_pix.last_pixel)
);
